### rtl/rswf_pkg.sv
package rswf_pkg;
  localparam int RS_ENTRIES = 32;
  localparam int RS_PHYS_REGS = 64;
  localparam int RS_DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_WAKEUP = 3'd1,
    OP_FLUSH = 3'd2,
    OP_RELEASE = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic alloc;
    logic wakeup;
    logic clear;
    logic flush_chk;
  } cell_ctl_t;
endpackage

### rtl/rswf_cell.sv
module rswf_cell #(
  parameter int ENTRIES = rswf_pkg::RS_ENTRIES,
  parameter int PHYS_REGS = rswf_pkg::RS_PHYS_REGS,
  parameter int DATA_WIDTH = rswf_pkg::RS_DATA_WIDTH,
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rswf_pkg::cell_ctl_t                 ctl,
  input  logic                                sel,
  input  logic                                rel_free,
  input  logic [$clog2(ENTRIES+1)-1:0]        in_wa,
  input  logic [$clog2(ENTRIES+1)-1:0]        in_wb,
  input  logic [$clog2(ENTRIES+1)-1:0]        wk_tag,
  input  logic [31:0]                         in_time,
  input  logic [$clog2(PHYS_REGS+1)-1:0]      in_dest,
  input  logic                                in_off,
  input  logic [DATA_WIDTH-1:0]               in_va,
  input  logic [DATA_WIDTH-1:0]               in_vb,
  input  logic [DATA_WIDTH-1:0]               in_bv,
  input  logic [31:0]                         fl_stamp,
  input  logic                                fl_self,
  output logic                                busy,
  output logic                                rdy,
  output logic                                fl_hit,
  output logic                                fl_free,
  output logic [$clog2(PHYS_REGS+1)-1:0]      dest,
  output logic [31:0]                         etime,
  output logic [DATA_WIDTH-1:0]               opa,
  output logic [DATA_WIDTH-1:0]               opb
);
  import rswf_pkg::*;
  localparam int TW = $clog2(ENTRIES+1);
  localparam int RW = $clog2(PHYS_REGS+1);
  localparam logic [TW-1:0] NO_TAG = TW'(ENTRIES);
  localparam logic [RW-1:0] NO_REG = RW'(PHYS_REGS);

  logic busy_r, rdy_r, off_r;
  logic [TW-1:0] wa_r, wb_r, wa_nxt, wb_nxt;
  logic [RW-1:0] dest_r;
  logic [31:0] time_r;
  logic [DATA_WIDTH-1:0] a_r, b_r;
  logic hit_a, hit_b, kill;

  assign hit_a = ctl.wakeup && (wa_r == wk_tag);
  assign hit_b = ctl.wakeup && (wb_r == wk_tag);
  assign fl_hit = busy_r && (time_r > fl_stamp) && !fl_self;
  assign fl_free = fl_hit && (dest_r < NO_REG) && !off_r;
  assign kill = ctl.clear || (ctl.flush_chk && fl_hit) || rel_free;
  assign wa_nxt = hit_a ? NO_TAG : wa_r;
  assign wb_nxt = hit_b ? NO_TAG : wb_r;

  always_ff @(posedge clk) begin
    if (!rst_n || kill) begin
      busy_r <= 1'b0;
      rdy_r <= 1'b0;
      off_r <= 1'b0;
      wa_r <= NO_TAG;
      wb_r <= NO_TAG;
      dest_r <= NO_REG;
      time_r <= '0;
      a_r <= '0;
      b_r <= '0;
    end else if (ctl.alloc && sel) begin
      busy_r <= 1'b1;
      time_r <= in_time;
      dest_r <= in_dest;
      off_r <= in_off;
      wa_r <= in_wa;
      wb_r <= in_wb;
      a_r <= in_va;
      b_r <= in_vb;
      rdy_r <= (in_wa == NO_TAG) && (in_wb == NO_TAG);
    end else if (hit_a || hit_b) begin
      wa_r <= wa_nxt;
      wb_r <= wb_nxt;
      if (hit_a) a_r <= in_bv;
      if (hit_b) b_r <= in_bv;
      rdy_r <= (wa_nxt == NO_TAG) && (wb_nxt == NO_TAG);
    end
  end

  assign busy = busy_r;
  assign rdy = rdy_r;
  assign dest = dest_r;
  assign etime = time_r;
  assign opa = a_r;
  assign opb = b_r;
endmodule

### rtl/reservation_station_wakeup_flush_top.sv
// Allocate, wakeup, clear: no result; the next item is taken whenever the output
// register is free. Release: the result is registered in the output register.
// Flush: after it is taken, the cells are scanned one per step, a step waiting while
// the output reg is stalled, each freed register leaving through the output reg,
// then the final item; no new item is taken until the final item is registered.
// Reset (synchronous, rst_n low) empties all entries; no clearing pass.
module reservation_station_wakeup_flush_top #(
  parameter int ENTRIES = rswf_pkg::RS_ENTRIES,
  parameter int PHYS_REGS = rswf_pkg::RS_PHYS_REGS,
  parameter int DATA_WIDTH = rswf_pkg::RS_DATA_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0], tag[7:3], stamp[39:8], dest_reg[46:40], dest_is_offset[47],
  // wait_tag_a[53:48], wait_tag_b[59:54], value_a[91:60], value_b[123:92],
  // broadcast_value[155:124], zero fill [159:156]
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // released[0], operand_a_out[32:1], operand_b_out[64:33], freed_valid[65],
  // freed_reg[71:66], latest_flushed[103:72]
  output logic [103:0] out_tdata,
  output logic         out_tlast
);
  import rswf_pkg::*;
  localparam int TW = $clog2(ENTRIES+1);
  localparam int IW = $clog2(ENTRIES);
  localparam int RW = $clog2(PHYS_REGS+1);

  logic [2:0] op;
  logic [4:0] tag;
  logic [31:0] stamp;
  logic [6:0] dreg;
  logic [5:0] wa6, wb6;
  logic [TW-1:0] wa, wb, wkt;
  logic [RW-1:0] dst;
  logic [DATA_WIDTH-1:0] va, vb, bv;
  logic tag_ok;

  assign op = in_tdata[2:0];
  assign tag = in_tdata[7:3];
  assign stamp = in_tdata[39:8];
  assign dreg = in_tdata[46:40];
  assign wa6 = in_tdata[53:48];
  assign wb6 = in_tdata[59:54];
  assign va = DATA_WIDTH'(in_tdata[91:60]);
  assign vb = DATA_WIDTH'(in_tdata[123:92]);
  assign bv = DATA_WIDTH'(in_tdata[155:124]);
  assign tag_ok = 32'(tag) < 32'(ENTRIES);
  assign wa = (32'(wa6) >= 32'(ENTRIES)) ? TW'(ENTRIES) : TW'(wa6);
  assign wb = (32'(wb6) >= 32'(ENTRIES)) ? TW'(ENTRIES) : TW'(wb6);
  assign wkt = TW'(tag);
  assign dst = (32'(dreg) >= 32'(PHYS_REGS)) ? RW'(PHYS_REGS) : RW'(dreg);

  // scan state
  logic scan_r, scan_nxt, fin_r;
  logic [IW-1:0] idx_r;
  logic [31:0] fst_r, lat_r;
  logic [4:0] ftag_r;
  logic ovalid_r, ovalid_nxt;
  logic [103:0] odata_r, odata_nxt;
  logic olast_r, olast_nxt;
  logic acc, oslot;

  assign oslot = !ovalid_r || out_tready;
  assign in_tready = !scan_r && !fin_r && oslot;
  assign acc = in_tvalid && in_tready;

  logic [ENTRIES-1:0] busy, rdy, fhit, ffree, sel, relf;
  logic [RW-1:0] dest [ENTRIES];
  logic [31:0] etime [ENTRIES];
  logic [DATA_WIDTH-1:0] opa [ENTRIES], opb [ENTRIES];
  cell_ctl_t ctl;
  logic rel_ok;

  assign ctl.alloc = acc && op == OP_ALLOC && tag_ok;
  assign ctl.wakeup = acc && op == OP_WAKEUP && tag_ok;
  assign ctl.clear = acc && op == OP_CLEAR;
  assign ctl.flush_chk = 1'b0;
  assign rel_ok = tag_ok && busy[IW'(tag)] && rdy[IW'(tag)];

  // one scan step per cycle while the output register is free: cell idx_r checked against the flusher time
  logic step, cur_hit, cur_free;
  assign step = scan_r && oslot;
  assign cur_hit = fhit[idx_r];
  assign cur_free = ffree[idx_r];

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      assign sel[g] = (32'(tag) == g);
      assign relf[g] = (acc && op == OP_RELEASE && sel[g] && rel_ok) ||
                       (step && idx_r == IW'(g) && fhit[g]);
      rswf_cell #(.ENTRIES(ENTRIES), .PHYS_REGS(PHYS_REGS),
                  .DATA_WIDTH(DATA_WIDTH), .IDX(g)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sel(sel[g]), .rel_free(relf[g]),
        .in_wa(wa), .in_wb(wb), .wk_tag(wkt), .in_time(stamp), .in_dest(dst),
        .in_off(in_tdata[47]), .in_va(va), .in_vb(vb), .in_bv(bv),
        .fl_stamp(fst_r), .fl_self(32'(ftag_r) == g),
        .busy(busy[g]), .rdy(rdy[g]), .fl_hit(fhit[g]), .fl_free(ffree[g]),
        .dest(dest[g]), .etime(etime[g]), .opa(opa[g]), .opb(opb[g]));
    end
  endgenerate

  logic [31:0] lat_nxt;
  assign lat_nxt = (cur_hit && etime[idx_r] > lat_r) ? etime[idx_r] : lat_r;

  always_comb begin
    scan_nxt = scan_r;
    if (acc && op == OP_FLUSH) scan_nxt = 1'b1;
    else if (step && idx_r == IW'(ENTRIES-1)) scan_nxt = 1'b0;
  end

  // output register: release result, freed registers, final flush item
  always_comb begin
    ovalid_nxt = ovalid_r && !oslot;
    olast_nxt = olast_r;
    odata_nxt = odata_r;
    if (acc && op == OP_RELEASE) begin
      ovalid_nxt = 1'b1;
      olast_nxt = 1'b1;
      odata_nxt = '0;
      if (rel_ok) begin
        odata_nxt[0] = 1'b1;
        odata_nxt[32:1] = 32'(opa[IW'(tag)]);
        odata_nxt[64:33] = 32'(opb[IW'(tag)]);
      end
    end else if (step && cur_free) begin
      ovalid_nxt = 1'b1;
      olast_nxt = 1'b0;
      odata_nxt = '0;
      odata_nxt[65] = 1'b1;
      odata_nxt[71:66] = 6'(dest[idx_r]);
    end else if (fin_r && oslot) begin
      ovalid_nxt = 1'b1;
      olast_nxt = 1'b1;
      odata_nxt = '0;
      odata_nxt[103:72] = lat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 1'b0;
      fin_r <= 1'b0;
      ovalid_r <= 1'b0;
      olast_r <= 1'b0;
      odata_r <= '0;
      idx_r <= '0;
      fst_r <= '0;
      ftag_r <= '0;
      lat_r <= '0;
    end else begin
      scan_r <= scan_nxt;
      ovalid_r <= ovalid_nxt;
      olast_r <= olast_nxt;
      odata_r <= odata_nxt;
      if (acc && op == OP_FLUSH) begin
        idx_r <= '0;
        fst_r <= stamp;
        ftag_r <= tag;
        lat_r <= '0;
      end else if (step) begin
        lat_r <= lat_nxt;
        idx_r <= idx_r + 1'b1;
        if (idx_r == IW'(ENTRIES-1)) fin_r <= 1'b1;
      end else if (fin_r && oslot) begin
        fin_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;

`ifndef SYNTHESIS
  a_no_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r |-> !in_tready) else $error("input taken during flush scan");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(scan_r) |-> fin_r) else $error("flush end missing");
`endif
endmodule
